@@ rtl/sprt_pkg.sv @@
// ----------------------------------------------------------------------------
// sprt_pkg
// Shared types and constants of the shared page reference count table.
// ----------------------------------------------------------------------------
package sprt_pkg;

  // table geometry
  localparam int ENTRIES   = 128;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PAGE_BITS = 12;
  localparam int REF_BITS  = 16;

  localparam logic [63:0]         PAGE_MASK = ~((64'd1 << PAGE_BITS) - 64'd1);
  localparam logic [REF_BITS-1:0] REF_MAX   = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE   = REF_BITS'(1);
  localparam logic [IDX_W-1:0]    IDX_LAST  = IDX_W'(ENTRIES - 1);

  // command codes (code 3 is unused)
  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_ADD = 2'd1,
    CMD_PUT = 2'd2
  } cmd_e;

  // result status codes
  typedef enum logic [2:0] {
    STS_HIT      = 3'd0,
    STS_INSERTED = 3'd1,
    STS_MISS     = 3'd2,
    STS_NOFILE   = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  // request beat
  typedef struct packed {
    logic [1:0]  command;
    logic        has_file;
    logic [31:0] device;
    logic [31:0] file_id;
    logic [63:0] vma_file_offset;
    logic [63:0] vma_start;
    logic [63:0] virt_addr;
    logic [63:0] frame_in;
  } in_t;

  // result beat
  typedef struct packed {
    status_e     status;
    logic [63:0] frame_out;
    logic        release_valid;
    logic [63:0] release_frame;
  } out_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic [31:0]         device;
    logic [31:0]         file_id;
    logic [63:0]         page_offset;
    logic [63:0]         frame;
    logic [REF_BITS-1:0] refs;
  } entry_t;

endpackage

@@ rtl/shared_page_refcount_table_top.sv @@
// ----------------------------------------------------------------------------
// shared_page_refcount_table_top
// Table of shared file pages keyed by device, file and page offset, with
// reference counts, held in one synchronous memory and scanned per command.
// ----------------------------------------------------------------------------
// Usage:
//   Request beats enter on in_valid_i / in_stall_o with one in_t payload; one
//   result beat per request leaves on out_valid_o / out_stall_i as an out_t.
//   A beat moves at a rising edge with valid high and stall low.
//   Commands get, add and put first form the page offset (two registered
//   64-bit adds, one at acceptance and one in the CALC state), then scan the
//   entry memory one entry per cycle through the registered read port, stop
//   at the first match, and write back in the update step. Unused commands
//   and requests without a file skip the scan and go straight to the result
//   step. The single memory read port and the linear scan set how long a
//   command takes.
//   One command is worked on at a time; the next request is accepted as soon
//   as the result sits in the output register, even if it is still stalled.
//   A result stalled by the receiver holds in the output register and a
//   finished command waits behind it before the block goes idle.
//   Reset clears the valid bit of every entry at once, so the table is empty
//   and ready right after reset; the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module shared_page_refcount_table_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sprt_pkg::in_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sprt_pkg::out_t    out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CALC = 5'b00010,
    S_SCAN = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // valid bits, one per entry
  logic [sprt_pkg::ENTRIES-1:0] valid_q, valid_d;

  // entry memory
  sprt_pkg::entry_t entry_mem [sprt_pkg::ENTRIES];
  sprt_pkg::entry_t rd_data_q;
  logic                       mem_we;
  logic [sprt_pkg::IDX_W-1:0] mem_waddr;
  sprt_pkg::entry_t           mem_wdata;

  // request and key
  sprt_pkg::in_t req_q;
  logic [63:0]   diff_q;
  logic [63:0]   off_q, off_d;

  // scan control
  logic [sprt_pkg::IDX_W-1:0] iss_q, iss_d;
  logic                       iss_done_q, iss_done_d;
  logic                       chk_vld_q, chk_vld_d;
  logic [sprt_pkg::IDX_W-1:0] chk_idx_q, chk_idx_d;
  logic                       hit_q, hit_d;
  logic [sprt_pkg::IDX_W-1:0] hit_idx_q, hit_idx_d;
  sprt_pkg::entry_t           hit_entry_q, hit_entry_d;
  logic                       free_q, free_d;
  logic [sprt_pkg::IDX_W-1:0] free_idx_q, free_idx_d;
  logic                       match;

  // result staging and output register
  sprt_pkg::out_t res_q, res_d;
  sprt_pkg::out_t out_q;
  logic           out_valid_q, out_valid_d;
  logic           in_accept;
  logic           load_out;

  logic [sprt_pkg::REF_BITS-1:0] refs_inc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign load_out    = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // key compare of the entry coming out of the memory
  assign match = (state_q == S_SCAN) && chk_vld_q && valid_q[chk_idx_q] &&
                 (rd_data_q.device == req_q.device) &&
                 (rd_data_q.file_id == req_q.file_id) &&
                 (rd_data_q.page_offset == off_q);

  // saturating count increment of the matched entry
  assign refs_inc = (hit_entry_q.refs == sprt_pkg::REF_MAX) ?
                    hit_entry_q.refs : hit_entry_q.refs + sprt_pkg::REF_ONE;

  // control path
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    iss_d       = iss_q;
    iss_done_d  = iss_done_q;
    chk_vld_d   = 1'b0;
    chk_idx_d   = iss_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_entry_d = hit_entry_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    off_d       = off_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = hit_idx_q;
    mem_wdata   = hit_entry_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d.status        = sprt_pkg::STS_MISS;
          res_d.frame_out     = '0;
          res_d.release_valid = 1'b0;
          res_d.release_frame = '0;
          if (!(in_data_i.command == sprt_pkg::CMD_GET ||
                in_data_i.command == sprt_pkg::CMD_ADD ||
                in_data_i.command == sprt_pkg::CMD_PUT)) begin
            state_d = S_FIN;
          end else if (!in_data_i.has_file) begin
            res_d.status = sprt_pkg::STS_NOFILE;
            state_d      = S_FIN;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        off_d      = (req_q.vma_file_offset + diff_q) & sprt_pkg::PAGE_MASK;
        iss_d      = '0;
        iss_done_d = 1'b0;
        hit_d      = 1'b0;
        free_d     = 1'b0;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        // issue side: one read per cycle
        if (!iss_done_q) begin
          chk_vld_d = 1'b1;
          if (iss_q == sprt_pkg::IDX_LAST) begin
            iss_done_d = 1'b1;
          end else begin
            iss_d = iss_q + 1'b1;
          end
        end
        // check side: data of the previous read
        if (match) begin
          hit_d       = 1'b1;
          hit_idx_d   = chk_idx_q;
          hit_entry_d = rd_data_q;
          chk_vld_d   = 1'b0;
          state_d     = S_UPD;
        end else if (chk_vld_q) begin
          if (!valid_q[chk_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (chk_idx_q == sprt_pkg::IDX_LAST) begin
            chk_vld_d = 1'b0;
            state_d   = S_UPD;
          end
        end
      end
      S_UPD: begin
        state_d = S_FIN;
        case (sprt_pkg::cmd_e'(req_q.command))
          sprt_pkg::CMD_GET: begin
            if (hit_q) begin
              mem_we              = 1'b1;
              mem_wdata.refs      = refs_inc;
              res_d.status        = sprt_pkg::STS_HIT;
              res_d.frame_out     = hit_entry_q.frame;
            end
          end
          sprt_pkg::CMD_ADD: begin
            if (hit_q) begin
              mem_we              = 1'b1;
              mem_wdata.refs      = refs_inc;
              res_d.status        = sprt_pkg::STS_HIT;
              res_d.release_valid = 1'b1;
              res_d.release_frame = req_q.frame_in;
            end else if (free_q) begin
              mem_we                = 1'b1;
              mem_waddr             = free_idx_q;
              mem_wdata.device      = req_q.device;
              mem_wdata.file_id     = req_q.file_id;
              mem_wdata.page_offset = off_q;
              mem_wdata.frame       = req_q.frame_in;
              mem_wdata.refs        = sprt_pkg::REF_ONE;
              valid_d[free_idx_q]   = 1'b1;
              res_d.status          = sprt_pkg::STS_INSERTED;
            end else begin
              res_d.status = sprt_pkg::STS_FULL;
            end
          end
          sprt_pkg::CMD_PUT: begin
            if (hit_q) begin
              res_d.status = sprt_pkg::STS_HIT;
              if (hit_entry_q.refs <= sprt_pkg::REF_ONE) begin
                // last reference: free the entry, hand back its frame
                valid_d[hit_idx_q]  = 1'b0;
                res_d.release_valid = 1'b1;
                res_d.release_frame = hit_entry_q.frame;
              end else begin
                mem_we         = 1'b1;
                mem_wdata.refs = hit_entry_q.refs - sprt_pkg::REF_ONE;
              end
            end
          end
          default: begin
            res_d.status = sprt_pkg::STS_MISS;
          end
        endcase
      end
      S_FIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      iss_q       <= '0;
      iss_done_q  <= 1'b1;
      chk_vld_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      iss_q       <= iss_d;
      iss_done_q  <= iss_done_d;
      chk_vld_q   <= chk_vld_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q  <= in_data_i;
      diff_q <= in_data_i.virt_addr - in_data_i.vma_start;
    end
    off_q       <= off_d;
    chk_idx_q   <= chk_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_entry_q <= hit_entry_d;
    free_idx_q  <= free_idx_d;
    res_q       <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= entry_mem[iss_q];
  end

  // a match is only taken from a valid entry during the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    match |-> (valid_q[chk_idx_q] && chk_vld_q))
    else $error("match on an invalid or unchecked entry");

  // the update step always hands over to the result step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |=> (state_q == S_FIN))
    else $error("update not followed by result step");

  // the output register is only loaded when it is free or being drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || !out_stall_i))
    else $error("output beat overwritten");

  // a released frame always comes with a hit status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.release_valid) |->
      (out_data_o.status == sprt_pkg::STS_HIT))
    else $error("release without hit");

  // memory is written only in the update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_UPD))
    else $error("memory write outside update step");

endmodule
